FILE: sv/pal_pkg.sv
package pal_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_e;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_POS  = 2'd2
    } status_e;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctl_state_e;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } shift_op_e;

    typedef struct packed {
        mode_e              mode;
        logic [7:0]         pos;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [7:0]         length;
        logic               empty_res;
        logic               full_res;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

FILE: sv/pal_ctrl.sv
module pal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pal_pkg::ctl_cmd_t  cmd
);

    pal_pkg::ctl_state_e state_reg;
    pal_pkg::ctl_state_e state_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                slot_free;

    // output register can take a new result this cycle
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = pal_pkg::S_EXEC;
                end
            end
            pal_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = pal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        unique case (state_reg)
            pal_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            pal_pkg::S_EXEC:
            begin
                cmd.exec = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pal_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: sv/pal_dp.sv
module pal_dp #(
    parameter int DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pal_pkg::ctl_cmd_t cmd,
    input  pal_pkg::req_t     req,
    output pal_pkg::rsp_t     rsp
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > 8) ? CW : 8;
    localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

    pal_pkg::req_t      req_reg;
    pal_pkg::rsp_t      rsp_reg;
    pal_pkg::rsp_t      rsp_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] entries_reg [DEPTH];
    logic signed [31:0] cell_next   [DEPTH];
    logic [DEPTH-1:0]   cell_we;

    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   at_pos;
    logic [CMP_W-1:0]   len_ext;
    logic               is_full;
    logic signed [31:0] rd_data;
    pal_pkg::shift_op_e op;

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(req_reg.pos);
    assign is_full = (cnt_ext == FULL_CNT);
    assign rd_data = entries_reg[pos_ext[IW-1:0]];

    always_comb
    begin
        op              = pal_pkg::OP_HOLD;
        at_pos          = pos_ext;
        count_next      = count_reg;
        rsp_next.data   = '0;
        rsp_next.status = pal_pkg::ST_OK;
        unique case (req_reg.mode)
            pal_pkg::MODE_INSERT:
            begin
                if (is_full)
                begin
                    rsp_next.status = pal_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    rsp_next.status = pal_pkg::ST_POS;
                end
                else
                begin
                    op         = pal_pkg::OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::MODE_APPEND:
            begin
                at_pos = cnt_ext;
                if (is_full)
                begin
                    rsp_next.status = pal_pkg::ST_FULL;
                end
                else
                begin
                    op         = pal_pkg::OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::MODE_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = pal_pkg::ST_POS;
                end
                else
                begin
                    op            = pal_pkg::OP_DELETE;
                    rsp_next.data = rd_data;
                    count_next    = count_reg - CW'(1);
                end
            end
            pal_pkg::MODE_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = pal_pkg::ST_POS;
                end
                else
                begin
                    rsp_next.data = rd_data;
                end
            end
            pal_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                op = pal_pkg::OP_HOLD;
            end
        endcase
        len_ext            = CMP_W'(count_next);
        rsp_next.length    = len_ext[7:0];
        rsp_next.empty_res = (len_ext == '0);
        rsp_next.full_res  = (len_ext == FULL_CNT);
    end

    // each cell takes the new value, its lower neighbor (insert) or its upper neighbor (delete)
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
        always_comb
        begin
            cell_we[i]   = 1'b0;
            cell_next[i] = req_reg.value;
            case (op)
                pal_pkg::OP_INSERT:
                begin
                    if (IDX == at_pos)
                    begin
                        cell_we[i] = cmd.exec;
                    end
                    else if (IDX > at_pos)
                    begin
                        cell_we[i]   = cmd.exec;
                        cell_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                pal_pkg::OP_DELETE:
                begin
                    if ((IDX >= at_pos) && (i < DEPTH - 1))
                    begin
                        cell_we[i]   = cmd.exec;
                        cell_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                default:
                begin
                    cell_we[i] = 1'b0;
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (cell_we[i])
            begin
                entries_reg[i] <= cell_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: sv/positional_array_list.sv
// Ordered list of up to DEPTH signed 32-bit values with insert, append, delete, read
// and clear at a list position; every request returns one response carrying data,
// status, length and empty/full flags. A request is first registered in the IDLE state;
// in the EXEC state every cell of the register array then loads its own
// value, the new value, or a neighbor's, so the whole shift completes at once. The
// response sits in an output register, and the next request is taken while it waits;
// a request stalls in the EXEC state only if the previous response is still unread.
// Entries need no clearing after reset; only the length counter is reset.
module positional_array_list #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pal_pkg::rsp_t rsp
);

    pal_pkg::ctl_cmd_t cmd;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

FILE: dv/positional_array_list_tb.sv
`timescale 1ns / 1ps

module positional_array_list_tb;

    localparam int DEPTH     = 128;
    localparam int N_RANDOM  = 850;
    localparam int HOLD_LONG = 400;

    typedef enum {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NOISE,
        PH_CLEAR
    } phase_e;

    // Tracks the list contents and the responses still owed by the block.
    class list_book;
        logic signed [31:0] cells [DEPTH];
        int unsigned        count;
        pal_pkg::rsp_t      rsp_due [$];
        int unsigned        errors;

        function new();
            count  = 0;
            errors = 0;
            foreach (cells[i])
            begin
                cells[i] = '0;
            end
        endfunction

        function void place(int unsigned at, logic signed [31:0] v);
            for (int unsigned i = count; i > at; i--)
            begin
                cells[i] = cells[i - 1];
            end
            cells[at] = v;
            count++;
        endfunction

        function void note_request(pal_pkg::req_t r);
            pal_pkg::rsp_t o;
            o        = '0;
            o.status = pal_pkg::ST_OK;
            case (r.mode)
                pal_pkg::MODE_INSERT:
                begin
                    if (count >= DEPTH)
                        o.status = pal_pkg::ST_FULL;
                    else if (r.pos > count)
                        o.status = pal_pkg::ST_POS;
                    else
                        place(r.pos, r.value);
                end
                pal_pkg::MODE_APPEND:
                begin
                    if (count >= DEPTH)
                        o.status = pal_pkg::ST_FULL;
                    else
                        place(count, r.value);
                end
                pal_pkg::MODE_DELETE:
                begin
                    if (r.pos >= count)
                        o.status = pal_pkg::ST_POS;
                    else
                    begin
                        o.data = cells[r.pos];
                        for (int unsigned i = r.pos; i + 1 < count; i++)
                        begin
                            cells[i] = cells[i + 1];
                        end
                        count--;
                    end
                end
                pal_pkg::MODE_READ:
                begin
                    if (r.pos >= count)
                        o.status = pal_pkg::ST_POS;
                    else
                        o.data = cells[r.pos];
                end
                pal_pkg::MODE_CLEAR:
                begin
                    count = 0;
                end
                default:
                begin
                end
            endcase
            o.length    = 8'(count);
            o.empty_res = (count == 0);
            o.full_res  = (count == DEPTH);
            rsp_due.push_back(o);
        endfunction

        function void check_response(pal_pkg::rsp_t got);
            pal_pkg::rsp_t exp;
            if (rsp_due.size() == 0)
            begin
                $display("%0t: unexpected response data=%0d status=%0d length=%0d",
                         $time, got.data, got.status, got.length,
                         " empty=%0b full=%0b", got.empty_res, got.full_res);
                errors++;
                return;
            end
            exp = rsp_due.pop_front();
            if (got !== exp)
            begin
                $display("%0t: mismatch expected data=%0d status=%0d length=%0d",
                         $time, exp.data, exp.status, exp.length,
                         " empty=%0b full=%0b", exp.empty_res, exp.full_res);
                $display("%0t:          actual   data=%0d status=%0d length=%0d",
                         $time, got.data, got.status, got.length,
                         " empty=%0b full=%0b", got.empty_res, got.full_res);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    pal_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    pal_pkg::rsp_t rsp;

    list_book    book;
    bit          hold_sink;
    bit          sink_holding;
    bit          no_gaps;
    int unsigned sent;

    positional_array_list #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Note requests before responses so ordering within an edge is fixed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                book.note_request(req);
            if (rsp_valid && rsp_ready)
                book.check_response(rsp);
        end
    end

    // Response sink: random ready bursts, plus one long hold-off on request.
    initial
    begin
        int unsigned sel;
        int unsigned len;
        int unsigned gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                rsp_ready    <= 1'b0;
                sink_holding = 1'b1;
                repeat (HOLD_LONG) @(posedge clk);
                sink_holding = 1'b0;
                hold_sink    = 1'b0;
            end
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(1, 8);
            else if (sel < 9)
                len = $urandom_range(20, 60);
            else
                len = $urandom_range(100, 200);
            rsp_ready <= 1'b1;
            repeat (len) @(posedge clk);
            sel = $urandom_range(0, 9);
            if (sel < 5)
                gap = 0;
            else if (sel < 9)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(15, 50);
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic pal_pkg::req_t mk(pal_pkg::mode_e m, int unsigned p,
                                         logic signed [31:0] v);
        pal_pkg::req_t r;
        r.mode  = m;
        r.pos   = 8'(p);
        r.value = v;
        return r;
    endfunction

    function automatic int unsigned pos_below(int unsigned n);
        return (n == 0) ? 0 : $urandom_range(0, n - 1);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send(input pal_pkg::req_t r);
        int unsigned gap;
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (book.rsp_due.size() != 0);
    endtask

    task automatic send_mixed(input int unsigned n);
        int unsigned sel;
        int unsigned c;
        repeat (n)
        begin
            sel = $urandom_range(0, 39);
            c   = book.count;
            if (sel < 10)
            begin
                if ($urandom_range(0, 7) == 0)
                    send(mk(pal_pkg::MODE_INSERT, c + 1, rand_value()));
                else
                    send(mk(pal_pkg::MODE_INSERT, $urandom_range(0, c), rand_value()));
            end
            else if (sel < 18)
                send(mk(pal_pkg::MODE_APPEND, $urandom_range(0, 255), rand_value()));
            else if (sel < 28)
                send(mk(pal_pkg::MODE_DELETE,
                        ($urandom_range(0, 7) == 0) ? c : pos_below(c), rand_value()));
            else if (sel < 37)
                send(mk(pal_pkg::MODE_READ,
                        ($urandom_range(0, 7) == 0) ? c : pos_below(c), rand_value()));
            else if (sel == 37)
                send(mk(pal_pkg::MODE_CLEAR, $urandom_range(0, 255), rand_value()));
            else
                send(mk(pal_pkg::mode_e'(3'(pal_pkg::MODE_CLEAR) + 3'($urandom_range(1, 3))),
                        $urandom_range(0, 255), rand_value()));
        end
    endtask

    task automatic send_fill();
        int unsigned guard;
        guard = 0;
        while (book.count < DEPTH && guard < 400 && sent < N_RANDOM)
        begin
            guard++;
            case ($urandom_range(0, 7))
                0: send(mk(pal_pkg::MODE_READ, pos_below(book.count), rand_value()));
                1, 2, 3: send(mk(pal_pkg::MODE_APPEND, $urandom_range(0, 255), rand_value()));
                default: send(mk(pal_pkg::MODE_INSERT, $urandom_range(0, book.count),
                                 rand_value()));
            endcase
        end
        // Push against the full list; the full check wins over a bad position.
        repeat ($urandom_range(3, 6))
        begin
            if ($urandom_range(0, 1) == 0)
                send(mk(pal_pkg::MODE_APPEND, $urandom_range(0, 255), rand_value()));
            else
                send(mk(pal_pkg::MODE_INSERT, $urandom_range(0, 255), rand_value()));
        end
        send(mk(pal_pkg::MODE_READ, DEPTH - 1, rand_value()));
    endtask

    task automatic send_drain();
        int unsigned guard;
        guard = 0;
        while (book.count > 0 && guard < 400 && sent < N_RANDOM)
        begin
            guard++;
            if ($urandom_range(0, 5) == 0)
                send(mk(pal_pkg::MODE_READ, pos_below(book.count), rand_value()));
            else
                send(mk(pal_pkg::MODE_DELETE, pos_below(book.count), rand_value()));
        end
        send(mk(pal_pkg::MODE_DELETE, $urandom_range(0, 255), rand_value()));
        send(mk(pal_pkg::MODE_READ, 0, rand_value()));
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n)
        begin
            send(mk(pal_pkg::mode_e'(3'($urandom_range(0, 7))), $urandom_range(0, 255),
                    $urandom));
        end
    endtask

    initial
    begin
        phase_e      ph;
        int unsigned phase_idx;
        int unsigned waited;
        book = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors on the empty list.
        send(mk(pal_pkg::MODE_READ, 0, 0));
        send(mk(pal_pkg::MODE_DELETE, 0, 0));
        send(mk(pal_pkg::MODE_INSERT, 1, 5));
        // Build a short list at front, middle and end.
        send(mk(pal_pkg::MODE_INSERT, 0, 32'sh7fff_ffff));
        send(mk(pal_pkg::MODE_APPEND, 255, 32'sh8000_0000));
        send(mk(pal_pkg::MODE_INSERT, 1, -32'sd1));
        send(mk(pal_pkg::MODE_INSERT, 0, 0));
        send(mk(pal_pkg::MODE_INSERT, 4, 32'sh5555_5555));
        send(mk(pal_pkg::MODE_READ, 0, 0));
        send(mk(pal_pkg::MODE_READ, 4, 0));
        send(mk(pal_pkg::MODE_READ, 5, 0));
        send(mk(pal_pkg::MODE_READ, 255, 0));
        send(mk(pal_pkg::MODE_DELETE, 2, 0));
        send(mk(pal_pkg::MODE_DELETE, 0, 0));
        send(mk(pal_pkg::MODE_DELETE, 2, 0));
        send(mk(pal_pkg::MODE_DELETE, 200, 0));
        // Unused mode codes leave the list alone.
        send(mk(pal_pkg::mode_e'(3'(pal_pkg::MODE_CLEAR) + 3'd1), 8'hff, 32'shaaaa_aaaa));
        send(mk(pal_pkg::mode_e'(3'(pal_pkg::MODE_CLEAR) + 3'd2), 8'hff, 32'shaaaa_aaaa));
        send(mk(pal_pkg::mode_e'(3'(pal_pkg::MODE_CLEAR) + 3'd3), 8'hff, 32'shaaaa_aaaa));
        send(mk(pal_pkg::MODE_CLEAR, 0, 0));
        send(mk(pal_pkg::MODE_READ, 0, 0));
        send(mk(pal_pkg::MODE_APPEND, 0, 32'sh1234_5678));
        send(mk(pal_pkg::MODE_READ, 0, 0));
        wait_drained();

        sent      = 0;
        phase_idx = 0;
        while (sent < N_RANDOM)
        begin
            if (phase_idx == 0)
                ph = PH_FILL;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ph = PH_FILL;
                    3, 4:    ph = PH_DRAIN;
                    5, 6, 7: ph = PH_MIXED;
                    8:       ph = PH_NOISE;
                    default: ph = PH_CLEAR;
                endcase
            end

            if (phase_idx == 2)
            begin
                // Stall the sink and keep offering back to back so the block backs up.
                req_valid <= 1'b0;
                hold_sink = 1'b1;
                wait (sink_holding);
                no_gaps   = 1'b1;
                send_mixed(40);
                no_gaps   = 1'b0;
                wait_drained();
            end

            if ($urandom_range(0, 4) == 0)
                no_gaps = 1'b1;
            case (ph)
                PH_FILL:  send_fill();
                PH_DRAIN: send_drain();
                PH_MIXED: send_mixed($urandom_range(30, 100));
                PH_NOISE: send_noise($urandom_range(10, 30));
                default:  send(mk(pal_pkg::MODE_CLEAR, $urandom_range(0, 255), rand_value()));
            endcase
            no_gaps = 1'b0;

            if (phase_idx == 4 || $urandom_range(0, 5) == 0)
                wait_drained();
            phase_idx++;
        end

        req_valid <= 1'b0;
        waited = 0;
        while (book.rsp_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (book.rsp_due.size() != 0)
        begin
            $display("%0t: %0d expected responses never arrived", $time, book.rsp_due.size());
            book.errors += book.rsp_due.size();
        end
        if (book.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pal_pkg.sv
sv/pal_ctrl.sv
sv/pal_dp.sv
sv/positional_array_list.sv
dv/positional_array_list_tb.sv
